@@ rtl/olst_pkg.sv @@
// Shared types and constants for the ordered list store.
// Used by the channel interfaces, the cell row and the top level; depends on nothing.
package olst_pkg;

  // Fixed widths of the word fields.
  localparam int VAL_W  = 32;
  localparam int POS_W  = 4;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  // Request codes carried on the input channel.
  typedef enum logic [REQ_W-1:0] {
    REQ_FRONT  = 2'd0,
    REQ_BACK   = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_DUMP   = 2'd3
  } req_t;

  // Status codes carried on the result channel.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  // Command broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CMD_HOLD       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_COMPARE    = 3'd3,
    CMD_CLOSE      = 3'd4,
    CMD_ROTATE     = 3'd5
  } cmd_t;

  // Control bundle from the sequencer to the row.
  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] key;
  } olst_ctrl_t;

endpackage

@@ rtl/olst_if.sv @@
// Valid/ready channel interfaces for requests and results of the ordered list store.
// Depends on olst_pkg for the field widths.
interface olst_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [olst_pkg::REQ_W-1:0]           req_type;
  logic signed [olst_pkg::VAL_W-1:0]    value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface olst_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [olst_pkg::STAT_W-1:0]          status;
  logic signed [olst_pkg::VAL_W-1:0]    entry_value;
  logic [olst_pkg::POS_W-1:0]           position;
  logic                                 last;

  modport source (output valid, output status, output entry_value, output position,
                  output last, input ready);
  modport sink   (input valid, input status, input entry_value, input position,
                  input last, output ready);
endinterface

@@ rtl/olst_cell.sv @@
// One storage cell of the list row: holds one entry and moves it to or from its neighbours.
// Depends on olst_pkg for the command bundle.
module olst_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic                              clk,
  input  olst_pkg::olst_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]                  count,
  input  logic signed [olst_pkg::VAL_W-1:0] left_val,
  input  logic signed [olst_pkg::VAL_W-1:0] right_val,
  input  logic signed [olst_pkg::VAL_W-1:0] head_val,
  input  logic                              kill_in,
  output logic                              kill_out,
  output logic                              hit,
  output logic signed [olst_pkg::VAL_W-1:0] val
);

  localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_IDX_1 = CNT_W'(IDX + 1);

  logic signed [olst_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                              hit_r, hit_nxt;
  logic                              occupied;

  assign occupied = MY_IDX < count;

  // A cell at or after the first match takes its right neighbour's entry.
  assign kill_out = kill_in | hit_r;
  assign hit      = hit_r;
  assign val      = val_r;

  // Next entry of the cell for each broadcast command.
  always_comb begin
    val_nxt = val_r;
    hit_nxt = hit_r;
    unique case (ctrl.cmd)
      olst_pkg::CMD_HOLD: begin
      end
      olst_pkg::CMD_PUSH_FRONT: begin
        val_nxt = (IDX == 0) ? ctrl.key : left_val;
      end
      olst_pkg::CMD_PUSH_BACK: begin
        if (MY_IDX == count) begin
          val_nxt = ctrl.key;
        end
      end
      olst_pkg::CMD_COMPARE: begin
        hit_nxt = occupied && (val_r == ctrl.key);
      end
      olst_pkg::CMD_CLOSE: begin
        if (kill_out) begin
          val_nxt = right_val;
        end
      end
      olst_pkg::CMD_ROTATE: begin
        val_nxt = (MY_IDX_1 == count) ? head_val : right_val;
      end
      default: begin
      end
    endcase
  end

  // Entry and match flag are always written before they are read, so they need no reset.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    hit_r <= hit_nxt;
  end

endmodule

@@ rtl/olst_row.sv @@
// Row of list cells linked to their neighbours, with the match chain running front to back.
// Depends on olst_pkg and olst_cell.
module olst_row #(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = 5
) (
  input  logic                              clk,
  input  olst_pkg::olst_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]                  count,
  output logic [CAPACITY-1:0]               hits,
  output logic signed [olst_pkg::VAL_W-1:0] head_val
);

  logic signed [olst_pkg::VAL_W-1:0] vals [CAPACITY];
  logic [CAPACITY:0]                 kill;

  assign kill[0]  = 1'b0;
  assign head_val = vals[0];

  // Each cell sees its two neighbours; the ends take the key or their own entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [olst_pkg::VAL_W-1:0] left_v, right_v;

    if (i == 0) begin : g_first
      assign left_v = ctrl.key;
    end else begin : g_inner_l
      assign left_v = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_v = vals[i];
    end else begin : g_inner_r
      assign right_v = vals[i+1];
    end

    olst_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (vals[0]),
      .kill_in   (kill[i]),
      .kill_out  (kill[i+1]),
      .hit       (hits[i]),
      .val       (vals[i])
    );
  end

endmodule

@@ rtl/ordered_list_store.sv @@
// Top level of the ordered list store: request sequencer, entry count and result register.
// Depends on olst_pkg, olst_if and olst_row.
//
//   channel  | dir | payload                                   | handshake
//   in_ch    | in  | req_type, value                           | valid/ready
//   out_ch   | out | status, entry_value, position, last        | valid/ready
//
// An insert updates the row on acceptance; a delete compares, then closes the gap in the row.
// A dump emits one word per cycle while out_ch takes them, as the cell row rotates once
// round; a dump of an empty list returns a single word with the empty status.
// A new request is taken once the previous one is finished and the result register is free.
// Back-pressure on out_ch stalls a dump in place; synchronous reset empties the list.
module ordered_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  olst_req_if.sink    in_ch,
  olst_rsp_if.source  out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_DUMP  = 3'b100
  } state_t;

  state_t                              state_r, state_nxt;
  logic [CNT_W-1:0]                    count_r, count_nxt;
  logic [IDX_W-1:0]                    dump_idx_r, dump_idx_nxt;
  logic                                out_valid_r, out_valid_nxt;
  olst_pkg::status_t                   status_r, status_nxt;
  logic signed [olst_pkg::VAL_W-1:0]   entry_r, entry_nxt;
  logic [olst_pkg::POS_W-1:0]          pos_r, pos_nxt;
  logic                                last_r, last_nxt;

  olst_pkg::olst_ctrl_t                ctrl;
  logic [CAPACITY-1:0]                 hits;
  logic signed [olst_pkg::VAL_W-1:0]   head_val;
  logic [IDX_W-1:0]                    hit_idx;
  logic                                out_free;
  logic                                accept;
  logic                                dump_last;

  olst_row #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_row (
    .clk      (clk),
    .ctrl     (ctrl),
    .count    (count_r),
    .hits     (hits),
    .head_val (head_val)
  );

  // The result register is free when empty or being emptied this cycle.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign dump_last   = (CNT_W'(dump_idx_r) + CNT_ONE) == count_r;

  // Position of the front-most matching cell.
  always_comb begin
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hits[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Request sequencing and result loading.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dump_idx_nxt  = dump_idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    entry_nxt     = entry_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    ctrl.cmd      = olst_pkg::CMD_HOLD;
    ctrl.key      = in_ch.value;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b0;
          entry_nxt     = '0;
          pos_nxt       = '0;
          last_nxt      = 1'b1;
          unique case (olst_pkg::req_t'(in_ch.req_type))
            olst_pkg::REQ_FRONT, olst_pkg::REQ_BACK: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_FULL) begin
                status_nxt = olst_pkg::STAT_FULL;
              end else begin
                status_nxt = olst_pkg::STAT_OK;
                count_nxt  = count_r + CNT_ONE;
                ctrl.cmd   = (olst_pkg::req_t'(in_ch.req_type) == olst_pkg::REQ_FRONT)
                             ? olst_pkg::CMD_PUSH_FRONT : olst_pkg::CMD_PUSH_BACK;
              end
            end
            olst_pkg::REQ_DELETE: begin
              ctrl.cmd  = olst_pkg::CMD_COMPARE;
              state_nxt = S_MATCH;
            end
            olst_pkg::REQ_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = olst_pkg::STAT_EMPTY;
              end else begin
                dump_idx_nxt = '0;
                state_nxt    = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // The result register is always free here: nothing was loaded on acceptance.
      S_MATCH: begin
        out_valid_nxt = 1'b1;
        entry_nxt     = '0;
        last_nxt      = 1'b1;
        state_nxt     = S_IDLE;
        if (|hits) begin
          ctrl.cmd   = olst_pkg::CMD_CLOSE;
          count_nxt  = count_r - CNT_ONE;
          status_nxt = olst_pkg::STAT_OK;
          pos_nxt    = olst_pkg::POS_W'(hit_idx);
        end else begin
          status_nxt = olst_pkg::STAT_MISSING;
          pos_nxt    = '0;
        end
      end

      // Emit the head cell, then rotate the row by one so the next entry comes to the front.
      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = olst_pkg::STAT_OK;
          entry_nxt     = head_val;
          pos_nxt       = olst_pkg::POS_W'(dump_idx_r);
          last_nxt      = dump_last;
          ctrl.cmd      = olst_pkg::CMD_ROTATE;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            dump_idx_nxt = dump_idx_r + IDX_W'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload and dump position.
  always_ff @(posedge clk) begin
    dump_idx_r <= dump_idx_nxt;
    status_r   <= status_nxt;
    entry_r    <= entry_nxt;
    pos_r      <= pos_nxt;
    last_r     <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.entry_value = entry_r;
  assign out_ch.position    = pos_r;
  assign out_ch.last        = last_r;

endmodule
